[rtl/frsu_pkg.sv]
package frsu_pkg;

    // FASTA text bytes with a meaning of their own
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] HEADER_BYTE  = 8'd62;

    // Command queue between the front and the back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = CMD_AW + 1;

    // Result output queue inside the back
    localparam int OUT_DEPTH = 2;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = OUT_AW + 1;

    typedef enum logic [1:0] {
        KIND_NAME   = 2'd0,
        KIND_SEQ    = 2'd1,
        KIND_LENGTH = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        OP_NAME  = 2'd0,
        OP_SEQ   = 2'd1,
        OP_CLOSE = 2'd2,
        OP_ERROR = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [63:0] record_length;
    } out_t;

endpackage

[rtl/frsu_front.sv]
module frsu_front
    import frsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  in_t  request,
    output logic cmd_push,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        MODE_AWAIT      = 5'b00001,
        MODE_NAME       = 5'b00010,
        MODE_LINE_START = 5'b00100,
        MODE_IN_LINE    = 5'b01000,
        MODE_ERROR      = 5'b10000
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  emit;
    op_t   op;
    logic  is_nl;
    logic  is_hdr;

    assign is_nl  = (request.byte_value == NEWLINE_BYTE);
    assign is_hdr = (request.byte_value == HEADER_BYTE);

    // Classify the request against the parse mode
    always_comb
    begin
        mode_next = mode_reg;
        emit      = 1'b0;
        op        = OP_NAME;
        if (request.func)
        begin
            mode_next = MODE_AWAIT;
            case (mode_reg)
                MODE_NAME, MODE_LINE_START, MODE_IN_LINE:
                begin
                    emit = 1'b1;
                    op   = OP_CLOSE;
                end
                MODE_ERROR:
                begin
                    emit = 1'b0;
                end
                default:
                begin
                    emit = 1'b1;
                    op   = OP_ERROR;
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_NAME:
                begin
                    emit = 1'b1;
                    op   = OP_NAME;
                    if (is_nl)
                    begin
                        mode_next = MODE_LINE_START;
                    end
                end
                MODE_LINE_START:
                begin
                    if (is_hdr)
                    begin
                        emit      = 1'b1;
                        op        = OP_CLOSE;
                        mode_next = MODE_NAME;
                    end
                    else if (!is_nl)
                    begin
                        emit      = 1'b1;
                        op        = OP_SEQ;
                        mode_next = MODE_IN_LINE;
                    end
                end
                MODE_IN_LINE:
                begin
                    if (is_nl)
                    begin
                        mode_next = MODE_LINE_START;
                    end
                    else
                    begin
                        emit = 1'b1;
                        op   = OP_SEQ;
                    end
                end
                MODE_ERROR:
                begin
                    mode_next = MODE_ERROR;
                end
                default:
                begin
                    if (is_hdr)
                    begin
                        mode_next = MODE_NAME;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        op        = OP_ERROR;
                        mode_next = MODE_ERROR;
                    end
                end
            endcase
        end
    end

    assign cmd_push = accept && emit;
    assign cmd.op   = op;
    assign cmd.data = request.byte_value;

    // Advance the parse mode on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_AWAIT;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

[rtl/frsu_cmd_fifo.sv]
module frsu_cmd_fifo
    import frsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              mem_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] wr_ptr_reg;
    logic [CMD_AW-1:0] rd_ptr_reg;
    logic [CMD_CW-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CMD_CW'(CMD_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/frsu_back.sv]
module frsu_back
    import frsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_empty,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic pop,
    output logic empty,
    output out_t result
);

    out_t              slot_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg;
    logic [OUT_AW-1:0] rd_ptr_reg;
    logic [OUT_CW-1:0] cnt_reg;
    logic [63:0]       seq_count_reg;
    logic [63:0]       seq_count_next;
    logic [63:0]       seq_count_inc;
    out_t              res;
    logic              out_pop;

    assign empty   = (cnt_reg == '0);
    assign out_pop = pop && !empty;
    assign cmd_pop = !cmd_empty && ((cnt_reg != OUT_CW'(OUT_DEPTH)) || out_pop);
    assign result  = slot_reg[rd_ptr_reg];
    assign seq_count_inc = seq_count_reg + 64'd1;

    // Carry out the command and build its result
    always_comb
    begin
        seq_count_next    = seq_count_reg;
        res.kind          = KIND_ERROR;
        res.out_byte      = 8'd0;
        res.record_length = 64'd0;
        case (cmd.op)
            OP_NAME:
            begin
                res.kind     = KIND_NAME;
                res.out_byte = cmd.data;
            end
            OP_SEQ:
            begin
                res.kind       = KIND_SEQ;
                res.out_byte   = cmd.data;
                seq_count_next = seq_count_inc;
            end
            OP_CLOSE:
            begin
                res.kind          = KIND_LENGTH;
                res.record_length = seq_count_reg;
                seq_count_next    = 64'd0;
            end
            default:
            begin
                res.kind = KIND_ERROR;
            end
        endcase
    end

    // Hold results until the receiver takes them
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

    // Advance the count, pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_count_reg <= 64'd0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd_pop)
            begin
                seq_count_reg <= seq_count_next;
                wr_ptr_reg    <= wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (cmd_pop && !out_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (out_pop && !cmd_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // A sequence byte bumps the count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && (cmd.op == OP_SEQ) |=> seq_count_reg == $past(seq_count_reg) + 64'd1)
        else $error("sequence count did not advance");

    // Closing a record reports the count and clears it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && (cmd.op == OP_CLOSE) |=> seq_count_reg == 64'd0)
        else $error("sequence count not cleared on close");

    // Name and error commands leave the count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && ((cmd.op == OP_NAME) || (cmd.op == OP_ERROR))
        |=> $stable(seq_count_reg))
        else $error("sequence count changed unexpectedly");

    // The result queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OUT_CW'(OUT_DEPTH))
        else $error("result queue overflow");

endmodule

[rtl/fasta_record_splitter_unit.sv]
// FASTA record splitter.
// Input channel: a queue-style write port. Drive request and raise push;
// the request is taken on a clock edge where full is low. request.func = 0
// carries one text byte, request.func = 1 marks end of input.
// Result channel: a queue-style read port. While empty is low, result holds
// the oldest result (name byte, sequence byte, record length or format
// error); raise pop to take it.
// Throughput: one request per cycle, sustained, while results are drained.
// Path: the edge that takes a request writes its command into the
// four-entry command queue; the back then writes its result into the
// two-entry result queue, from which the receiver pops it.
// Requests that produce no result (blank lines, the leading '>', bytes
// after an error) are consumed when accepted and write no command.
// Stall: when the receiver holds pop low, the result queue fills, the back
// stops draining commands, and full rises once the command queue is full;
// nothing is lost.
// Reset: rst_n (asynchronous, active low) empties both queues, clears the
// sequence count and returns the parser to waiting for the first '>'.
module fasta_record_splitter_unit
    import frsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  request,
    input  logic pop,
    output logic empty,
    output out_t result
);

    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_head;
    logic cmd_empty;
    logic cmd_pop;

    assign accept = push && !full;

    frsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .request  (request),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    frsu_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd_in),
        .pop      (cmd_pop),
        .head     (cmd_head),
        .empty    (cmd_empty),
        .full     (full)
    );

    frsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
